### hdl/ftau_pkg.sv
// shared constants, types and rounding helper for the fast trig approximation unit
package ftau_pkg;

  // fixed-point format of operands and results
  localparam int FRACTION_BITS = 16;
  localparam int ANG_SH        = 28 - FRACTION_BITS;
  localparam int ATAN_SH       = 30 - FRACTION_BITS;
  localparam int ANG_W         = 32 + ANG_SH + 2;
  localparam int QUOT_W        = 31;
  localparam int RES_W         = 20;
  localparam int MAG_W         = 36;

  // q30 constants
  localparam logic [63:0] PI_Q30_W    = 64'd3373259426;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [63:0] B_FULL      = 64'h4000_0000_0000_0000 / PI_Q30_W;
  localparam logic [63:0] C_FULL      = (B_FULL << 30) / PI_Q30_W;
  localparam logic [63:0] K_FULL      = (64'd28 * 64'h4000_0000 + 64'd50) / 64'd100;
  localparam logic [63:0] P_FULL      = (64'd225 * 64'h4000_0000 + 64'd500) / 64'd1000;
  localparam logic [30:0] B_Q30       = B_FULL[30:0];
  localparam logic [28:0] C_Q30       = C_FULL[28:0];
  localparam logic [28:0] K_Q30       = K_FULL[28:0];
  localparam logic [27:0] P_Q30       = P_FULL[27:0];

  // q28 angle constants
  localparam logic signed [ANG_W-1:0] HALF_PI_Q28 = ANG_W'(421657428);
  localparam logic signed [ANG_W-1:0] PI_Q28      = ANG_W'(843314857);
  localparam logic signed [ANG_W-1:0] TWO_PI_Q28  = ANG_W'(1686629713);
  localparam logic signed [ANG_W-1:0] ANGLE_LIM   = ANG_W'(1610612736);

  // result saturation: 4.0, capped at the 20-bit maximum
  localparam int OUT_LIM_I = ((4 << FRACTION_BITS) > 524287) ? 524287 : (4 << FRACTION_BITS);
  localparam logic [RES_W-1:0] OUT_LIM = RES_W'(OUT_LIM_I);

  typedef enum logic [1:0] {
    OP_ATAN2  = 2'd0,
    OP_SINE   = 2'd1,
    OP_COSINE = 2'd2
  } op_e;

  // per-item flags that ride along the divider pipelines
  typedef struct packed {
    op_e              op;
    logic             x_zero;
    logic             y_zero;
    logic             x_neg;
    logic             y_neg;
    logic             opp;
    logic             swap;
    logic [RES_W-1:0] sin_res;
  } side_t;

  // round half away from zero, saturate, put the sign back
  function automatic logic [RES_W-1:0] finish(input logic neg, input logic [MAG_W-1:0] mag,
                                              input int shift);
    logic [MAG_W-1:0] rnd;
    logic [RES_W-1:0] r;
    rnd = (mag + (MAG_W'(1) << (shift - 1))) >> shift;
    if (rnd > MAG_W'(OUT_LIM)) begin
      r = OUT_LIM;
    end else begin
      r = rnd[RES_W-1:0];
    end
    return neg ? (RES_W'(0) - r) : r;
  endfunction

endpackage

### hdl/ftau_div.sv
// pipelined restoring divider, one quotient bit per stage, for num <= den
module ftau_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [31:0]                   num_i,
  input  logic [31:0]                   den_i,
  input  ftau_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [ftau_pkg::QUOT_W-1:0]   quot_o,
  output ftau_pkg::side_t               side_o
);

  localparam int QW = ftau_pkg::QUOT_W;

  logic [QW-1:0]   vld_q;
  logic [31:0]     rem_q  [QW];
  logic [31:0]     den_q  [QW];
  logic [QW-1:0]   quot_q [QW];
  ftau_pkg::side_t side_q [QW];

  logic [32:0]     rem_in  [QW];
  logic [31:0]     den_in  [QW];
  logic [QW-1:0]   quot_in [QW];
  ftau_pkg::side_t side_in [QW];
  logic [32:0]     diff    [QW];
  logic [QW-1:0]   ge;
  logic [QW-1:0]   quot_d  [QW];
  logic [31:0]     rem_d   [QW];

  // stage inputs: first stage takes the operands, later ones shift the remainder
  always_comb begin
    rem_in[0]  = {1'b0, num_i};
    den_in[0]  = den_i;
    quot_in[0] = '0;
    side_in[0] = side_i;
    for (int i = 1; i < QW; i++) begin
      rem_in[i]  = {rem_q[i-1], 1'b0};
      den_in[i]  = den_q[i-1];
      quot_in[i] = quot_q[i-1];
      side_in[i] = side_q[i-1];
    end
  end

  // compare and subtract in every stage
  always_comb begin
    for (int i = 0; i < QW; i++) begin
      diff[i]   = rem_in[i] - {1'b0, den_in[i]};
      ge[i]     = rem_in[i] >= {1'b0, den_in[i]};
      quot_d[i] = quot_in[i];
      quot_d[i][QW-1-i] = ge[i];
      rem_d[i]  = ge[i] ? diff[i][31:0] : rem_in[i][31:0];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], valid_i};
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QW; i++) begin
        rem_q[i]  <= rem_d[i];
        den_q[i]  <= den_in[i];
        quot_q[i] <= quot_d[i];
        side_q[i] <= side_in[i];
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### hdl/fast_trig_approximation_unit.sv
// fast trig unit: atan2 by rational form, sine and cosine by refined parabola
// every operation passes the same pipeline from input transfer to result valid
// most of the latency is in the two 31-stage pipelined dividers of atan2
// throughput: one item per cycle while the output is not stalled, every stage is registered
// a stalled output freezes the whole pipeline, no item is lost or repeated
// reset: asynchronous active low, clears all valid bits; payload registers are not reset
module fast_trig_approximation_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           stall_o,
  input  logic [1:0]                     operation_i,
  input  logic signed [31:0]             first_operand_i,
  input  logic signed [31:0]             second_operand_i,
  output logic                           valid_o,
  input  logic                           stall_i,
  output logic signed [ftau_pkg::RES_W-1:0] result_o
);

  localparam int AW = ftau_pkg::ANG_W;
  localparam int MW = ftau_pkg::MAG_W;
  localparam int QW = ftau_pkg::QUOT_W;
  localparam int RW = ftau_pkg::RES_W;

  typedef struct packed {
    logic [31:0]     num;
    logic [31:0]     den;
    ftau_pkg::side_t side;
  } carry_t;

  logic en;

  // valid chains
  logic [10:0] sv_q;
  logic [1:0]  av_q;
  logic [2:0]  bv_q;
  logic        d1_vld;
  logic        d2_vld;

  // front stages
  ftau_pkg::op_e        op0_q;
  logic signed [31:0]   x0_q;
  logic signed [31:0]   y0_q;
  carry_t               car1_d, car1_q, car2_q, car3_q, car4_q, car5_q;
  carry_t               car6_q, car7_q, car8_q, car9_q, car10_d, car10_q;
  logic [31:0]          ax, by;
  logic signed [AW-1:0] u1_d, u1_q, u2_d, u2_q;
  logic [30:0]          m3_d, m3_q;
  logic                 un3_q, un4_q, un5_q;
  logic [61:0]          pbm, psq;
  logic [31:0]          bm4_q, bm5_q;
  logic [33:0]          sq4_q;
  logic [62:0]          pcq;
  logic [32:0]          cq5_q;
  logic signed [33:0]   yv;
  logic [33:0]          ayv;
  logic [30:0]          ay6_q, ay7_q, ay8_q;
  logic                 sg6_q, sg7_q, sg8_q, sg9_q;
  logic [61:0]          pt1;
  logic [58:0]          ppa;
  logic [33:0]          t17_q;
  logic [28:0]          pa7_q, pa8_q;
  logic [61:0]          ppt;
  logic [31:0]          pt8_q;
  logic [MW-1:0]        mag9_q;

  // atan2 back stages
  logic [QW-1:0]        r1;
  ftau_pkg::side_t      d1_side, d2_side;
  logic [61:0]          pr;
  logic [QW-1:0]        r_a1_q, r_a2_q;
  logic [30:0]          r2_a1_q;
  ftau_pkg::side_t      side_a1_q, side_a2_q, side_b1_q, side_b2_q;
  logic [59:0]          pk;
  logic [31:0]          d_a2_q;
  logic [QW-1:0]        f2;
  logic signed [34:0]   fs, at_s, at2, v_d, v_q;
  logic [34:0]          absv;
  logic [MW-1:0]        mag_b2_q;
  logic                 neg_b2_q;
  logic [RW-1:0]        res_d, result_q;

  // global advance: hold everything while the result waits
  assign en      = !(bv_q[2] && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      av_q <= '0;
      bv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[9:0], valid_i};
      av_q <= {av_q[0], d1_vld};
      bv_q <= {bv_q[1:0], d2_vld};
    end
  end

  // stage 1: magnitudes, ordering and flags for atan2; q28 angle with cosine shift
  always_comb begin
    ax = x0_q[31] ? (32'd0 - x0_q) : x0_q;
    by = y0_q[31] ? (32'd0 - y0_q) : y0_q;
    car1_d.side.op      = op0_q;
    car1_d.side.x_zero  = (x0_q == 32'sd0);
    car1_d.side.y_zero  = (y0_q == 32'sd0);
    car1_d.side.x_neg   = x0_q[31];
    car1_d.side.y_neg   = y0_q[31];
    car1_d.side.opp     = x0_q[31] ^ y0_q[31];
    car1_d.side.swap    = (by >= ax);
    car1_d.side.sin_res = '0;
    car1_d.num          = (by >= ax) ? ax : by;
    car1_d.den          = (by >= ax) ? by : ax;
    u1_d = ({{(AW-32){x0_q[31]}}, x0_q} << ftau_pkg::ANG_SH)
         + ((op0_q == ftau_pkg::OP_COSINE) ? ftau_pkg::HALF_PI_Q28 : AW'(0));
  end

  // stage 2: cosine wrap above pi
  assign u2_d = ((car1_q.side.op == ftau_pkg::OP_COSINE) && (u1_q > ftau_pkg::PI_Q28)) ?
                (u1_q - ftau_pkg::TWO_PI_Q28) : u1_q;

  // stage 3: clamp to +/-6 and take the magnitude
  always_comb begin
    if (u2_q[AW-1]) begin
      m3_d = (u2_q < -ftau_pkg::ANGLE_LIM) ? ftau_pkg::ANGLE_LIM[30:0] : 31'(-u2_q);
    end else begin
      m3_d = (u2_q > ftau_pkg::ANGLE_LIM) ? ftau_pkg::ANGLE_LIM[30:0] : u2_q[30:0];
    end
  end

  // sine products
  assign pbm = 62'(ftau_pkg::B_Q30) * 62'(m3_q);
  assign psq = 62'(m3_q) * 62'(m3_q);
  assign pcq = 63'(ftau_pkg::C_Q30) * 63'(sq4_q);
  assign yv  = $signed({2'b00, bm5_q}) - $signed({1'b0, cq5_q});
  assign ayv = yv[33] ? 34'(-yv) : 34'(yv);
  assign pt1 = 62'(ay6_q) * 62'(ay6_q);
  assign ppa = 59'(ftau_pkg::P_Q30) * 59'(ay6_q);
  assign ppt = 62'(ftau_pkg::P_Q30) * 62'(t17_q);

  // stage 10: round the sine magnitude into the sideband
  always_comb begin
    car10_d = car9_q;
    car10_d.side.sin_res = ftau_pkg::finish(sg9_q, mag9_q, ftau_pkg::ANG_SH);
  end

  // front pipeline registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q   <= ftau_pkg::op_e'(operation_i);
      x0_q    <= first_operand_i;
      y0_q    <= second_operand_i;
      car1_q  <= car1_d;
      u1_q    <= u1_d;
      car2_q  <= car1_q;
      u2_q    <= u2_d;
      car3_q  <= car2_q;
      m3_q    <= m3_d;
      un3_q   <= u2_q[AW-1];
      car4_q  <= car3_q;
      bm4_q   <= pbm[61:30];
      sq4_q   <= psq[61:28];
      un4_q   <= un3_q;
      car5_q  <= car4_q;
      bm5_q   <= bm4_q;
      cq5_q   <= pcq[62:30];
      un5_q   <= un4_q;
      car6_q  <= car5_q;
      ay6_q   <= ayv[30:0];
      sg6_q   <= un5_q ^ yv[33];
      car7_q  <= car6_q;
      ay7_q   <= ay6_q;
      t17_q   <= pt1[61:28];
      pa7_q   <= ppa[58:30];
      sg7_q   <= sg6_q;
      car8_q  <= car7_q;
      ay8_q   <= ay7_q;
      pa8_q   <= pa7_q;
      pt8_q   <= ppt[61:30];
      sg8_q   <= sg7_q;
      car9_q  <= car8_q;
      mag9_q  <= MW'(ay8_q) + MW'(pt8_q) - MW'(pa8_q);
      sg9_q   <= sg8_q;
      car10_q <= car10_d;
    end
  end

  // ratio r = min/max
  ftau_div u_div_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sv_q[10]),
    .num_i   (car10_q.num),
    .den_i   (car10_q.den),
    .side_i  (car10_q.side),
    .valid_o (d1_vld),
    .quot_o  (r1),
    .side_o  (d1_side)
  );

  // denominator 1 + 0.28 r^2
  assign pr = 62'(r1) * 62'(r1);
  assign pk = 60'(ftau_pkg::K_Q30) * 60'(r2_a1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_a1_q    <= r1;
      r2_a1_q   <= pr[60:30];
      side_a1_q <= d1_side;
      r_a2_q    <= r_a1_q;
      d_a2_q    <= 32'h4000_0000 + 32'(pk[59:30]);
      side_a2_q <= side_a1_q;
    end
  end

  // f = r / (1 + 0.28 r^2)
  ftau_div u_div_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (av_q[1]),
    .num_i   ({1'b0, r_a2_q}),
    .den_i   (d_a2_q),
    .side_i  (side_a2_q),
    .valid_o (d2_vld),
    .quot_o  (f2),
    .side_o  (d2_side)
  );

  // octant mirror and quadrant correction
  always_comb begin
    fs   = $signed({4'b0000, f2});
    at_s = d2_side.opp ? -fs : fs;
    at2  = $signed({4'b0000, ftau_pkg::HALF_PI_Q30}) - at_s;
    if (!d2_side.swap) begin
      if (d2_side.x_neg) begin
        v_d = d2_side.y_neg ? (at_s - $signed({3'b000, ftau_pkg::PI_Q30}))
                            : (at_s + $signed({3'b000, ftau_pkg::PI_Q30}));
      end else begin
        v_d = at_s;
      end
    end else begin
      v_d = d2_side.y_neg ? (at2 - $signed({3'b000, ftau_pkg::PI_Q30})) : at2;
    end
  end

  assign absv = v_q[34] ? 35'(-v_q) : 35'(v_q);

  // result select
  always_comb begin
    case (side_b2_q.op)
      ftau_pkg::OP_ATAN2: begin
        if (side_b2_q.x_zero) begin
          res_d = side_b2_q.y_zero ? RW'(0) :
                  ftau_pkg::finish(side_b2_q.y_neg, MW'(ftau_pkg::HALF_PI_Q30),
                                   ftau_pkg::ATAN_SH);
        end else begin
          res_d = ftau_pkg::finish(neg_b2_q, mag_b2_q, ftau_pkg::ATAN_SH);
        end
      end
      ftau_pkg::OP_SINE:   res_d = side_b2_q.sin_res;
      ftau_pkg::OP_COSINE: res_d = side_b2_q.sin_res;
      default:             res_d = '0;
    endcase
  end

  // back pipeline registers and output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q       <= v_d;
      side_b1_q <= d2_side;
      mag_b2_q  <= {1'b0, absv};
      neg_b2_q  <= v_q[34];
      side_b2_q <= side_b1_q;
      result_q  <= res_d;
    end
  end

  assign valid_o  = bv_q[2];
  assign result_o = result_q;

`ifndef SYNTHESIS
  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (($signed(result_o) <= $signed(ftau_pkg::OUT_LIM)) &&
                 ($signed(result_o) >= -$signed(ftau_pkg::OUT_LIM))))
    else $error("result beyond saturation limit");

  a_input_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> sv_q[0])
    else $error("accepted transfer not captured in first stage");

  a_last_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bv_q[1] && !stall_o) |=> valid_o)
    else $error("finished item did not reach the output register");
`endif

endmodule
